### hdl/fat_chain_block_allocator_defines.svh
// Assertion macros for the block allocator checks.
`ifndef FAT_CHAIN_BLOCK_ALLOCATOR_DEFINES_SVH
`define FAT_CHAIN_BLOCK_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define FCBA_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fcba check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define FCBA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fcba check failed");

`endif

### hdl/fcba_pkg.sv
// Shared types and constants of the block allocator.
`default_nettype none

package fcba_pkg;

	localparam int NUM_BLOCKS_DFLT = 256;
	localparam int MAX_ENTRIES     = 256;
	localparam logic [8:0] END_MARK = 9'h1FF;

	typedef enum logic [1:0] {
		REQ_ALLOC = 2'd0,
		REQ_FREE  = 2'd1,
		REQ_READ  = 2'd2
	} req_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NOSPACE = 2'd1,
		ST_BAD     = 2'd2
	} status_t;

	typedef struct packed {
		logic [7:0] rd_addr;
		logic       wr_en;
		logic [7:0] wr_addr;
		logic [8:0] wr_data;
	} mem_req_t;

	typedef struct packed {
		status_t    status;
		logic [7:0] first_block;
		logic [8:0] entry_value;
		logic       block_used;
		logic [7:0] free_blocks;
		logic [7:0] chain_count;
	} result_t;

endpackage

`default_nettype wire

### hdl/fcba_table.sv
// Allocation table memory: one write and one registered read port, valid bits.
`default_nettype none

module fcba_table #(
	parameter int DEPTH = fcba_pkg::MAX_ENTRIES
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  fcba_pkg::mem_req_t    mem_req,
	output logic [8:0]            rd_data
);

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [8:0]       mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [8:0]       rd_data_q;
	logic             rd_vld_q;
	logic             rd_zero_q;

	// Payload array: no reset, unwritten entries are masked by the valid bits
	always_ff @(posedge clk) begin
		if (mem_req.wr_en) begin
			mem[mem_req.wr_addr[IDX_W-1:0]] <= mem_req.wr_data;
		end
		rd_data_q <= mem[mem_req.rd_addr[IDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_q  <= 1'b0;
			rd_zero_q <= 1'b0;
		end else begin
			if (mem_req.wr_en) begin
				vld_q[mem_req.wr_addr[IDX_W-1:0]] <= 1'b1;
			end
			rd_vld_q  <= vld_q[mem_req.rd_addr[IDX_W-1:0]];
			rd_zero_q <= (mem_req.rd_addr == 8'd0);
		end
	end

	// Block 0 is reserved and never written: it always reads as the end marker
	assign rd_data = rd_zero_q ? fcba_pkg::END_MARK : (rd_vld_q ? rd_data_q : 9'd0);

endmodule

`default_nettype wire

### hdl/fcba_seq.sv
// Request sequencer: table scan, chain walk and the counters.
`default_nettype none

module fcba_seq #(
	parameter int DEPTH = fcba_pkg::MAX_ENTRIES
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	input  wire logic [1:0]     req_type,
	input  wire logic [7:0]     block_count,
	input  wire logic [7:0]     start_block,
	input  wire logic           out_free,
	output logic                in_stall,
	output fcba_pkg::mem_req_t  mem_req,
	input  wire logic [8:0]     rd_data,
	output logic                res_valid,
	output fcba_pkg::result_t   res
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_ALLOC_RD,
		S_ALLOC_CHK,
		S_ALLOC_END,
		S_FREE_RD,
		S_FREE_CHK,
		S_FREE_END,
		S_READ_RD,
		S_READ_CHK,
		S_DONE
	} state_t;

	localparam logic [7:0] TOP_BLK = 8'(DEPTH - 1);
	localparam logic [8:0] DEPTH_W = 9'(DEPTH);

	state_t              state_q;
	logic [7:0]          cnt_q;
	logic [7:0]          cur_q;
	logic [7:0]          prev_q;
	logic [7:0]          taken_q;
	logic [7:0]          steps_q;
	logic                head_q;
	logic [7:0]          free_q;
	logic [7:0]          zero_q;
	logic [7:0]          chain_q;
	fcba_pkg::status_t   status_q;
	logic [7:0]          first_q;
	logic [8:0]          entry_q;
	logic                used_q;

	logic [8:0] free_sum;
	logic [7:0] free_new;
	logic       last_step;
	logic       walk_stop;
	logic       blk_out;

	assign free_sum  = {1'b0, free_q} + {1'b0, cnt_q};
	assign free_new  = (free_sum > {1'b0, TOP_BLK}) ? TOP_BLK : free_sum[7:0];
	assign last_step = (({1'b0, steps_q} + 9'd1) == DEPTH_W);
	assign walk_stop = (rd_data == fcba_pkg::END_MARK) || (rd_data == 9'd0) ||
	                   (rd_data >= DEPTH_W) || last_step;
	assign blk_out   = ({1'b0, start_block} >= DEPTH_W);

	assign in_stall  = (state_q != S_IDLE);
	assign res_valid = (state_q == S_DONE) && out_free;

	always_comb begin
		res.status      = status_q;
		res.first_block = first_q;
		res.entry_value = entry_q;
		res.block_used  = used_q;
		res.free_blocks = free_q;
		res.chain_count = chain_q;
	end

	// Table port: read the current block, write links or clears
	always_comb begin
		mem_req.rd_addr = cur_q;
		mem_req.wr_en   = 1'b0;
		mem_req.wr_addr = prev_q;
		mem_req.wr_data = {1'b0, cur_q};
		unique case (state_q)
			S_ALLOC_CHK: begin
				mem_req.wr_en = (rd_data == 9'd0) && (taken_q != 8'd0);
			end
			S_ALLOC_END: begin
				mem_req.wr_en   = 1'b1;
				mem_req.wr_data = fcba_pkg::END_MARK;
			end
			S_FREE_CHK: begin
				mem_req.wr_en   = !(head_q && (rd_data == 9'd0));
				mem_req.wr_addr = cur_q;
				mem_req.wr_data = 9'd0;
			end
			default: begin
				mem_req.wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			cur_q    <= '0;
			prev_q   <= '0;
			taken_q  <= '0;
			steps_q  <= '0;
			head_q   <= 1'b0;
			free_q   <= TOP_BLK;
			zero_q   <= TOP_BLK;
			chain_q  <= '0;
			status_q <= fcba_pkg::ST_OK;
			first_q  <= '0;
			entry_q  <= '0;
			used_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cnt_q    <= block_count;
						cur_q    <= start_block;
						taken_q  <= '0;
						steps_q  <= '0;
						head_q   <= 1'b1;
						status_q <= fcba_pkg::ST_OK;
						first_q  <= '0;
						entry_q  <= '0;
						used_q   <= 1'b0;
						state_q  <= S_DONE;
						unique case (req_type)
							fcba_pkg::REQ_ALLOC: begin
								cur_q <= 8'd1;
								if (block_count == 8'd0) begin
									status_q <= fcba_pkg::ST_BAD;
								end else if (block_count > free_q ||
								             block_count > zero_q) begin
									status_q <= fcba_pkg::ST_NOSPACE;
								end else begin
									state_q <= S_ALLOC_RD;
								end
							end
							fcba_pkg::REQ_FREE: begin
								if (block_count == 8'd0 || start_block == 8'd0 || blk_out) begin
									status_q <= fcba_pkg::ST_BAD;
								end else begin
									state_q <= S_FREE_RD;
								end
							end
							fcba_pkg::REQ_READ: begin
								if (blk_out) begin
									status_q <= fcba_pkg::ST_BAD;
								end else begin
									state_q <= S_READ_RD;
								end
							end
							default: begin
								status_q <= fcba_pkg::ST_BAD;
							end
						endcase
					end
				end
				S_ALLOC_RD: begin
					state_q <= S_ALLOC_CHK;
				end
				S_ALLOC_CHK: begin
					if (rd_data == 9'd0) begin
						prev_q  <= cur_q;
						taken_q <= 8'(taken_q + 8'd1);
						if (taken_q == 8'd0) begin
							first_q <= cur_q;
						end
					end
					if ((rd_data == 9'd0) && (8'(taken_q + 8'd1) == cnt_q)) begin
						state_q <= S_ALLOC_END;
					end else begin
						cur_q   <= 8'(cur_q + 8'd1);
						state_q <= S_ALLOC_RD;
					end
				end
				S_ALLOC_END: begin
					free_q  <= 8'(free_q - cnt_q);
					zero_q  <= 8'(zero_q - cnt_q);
					chain_q <= (chain_q == 8'hFF) ? chain_q : 8'(chain_q + 8'd1);
					state_q <= S_DONE;
				end
				S_FREE_RD: begin
					state_q <= S_FREE_CHK;
				end
				S_FREE_CHK: begin
					head_q <= 1'b0;
					if (head_q && (rd_data == 9'd0)) begin
						status_q <= fcba_pkg::ST_BAD;
						state_q  <= S_DONE;
					end else begin
						if (rd_data != 9'd0) begin
							zero_q <= 8'(zero_q + 8'd1);
						end
						steps_q <= 8'(steps_q + 8'd1);
						if (walk_stop) begin
							state_q <= S_FREE_END;
						end else begin
							cur_q   <= rd_data[7:0];
							state_q <= S_FREE_RD;
						end
					end
				end
				S_FREE_END: begin
					free_q  <= free_new;
					chain_q <= (chain_q == 8'd0) ? chain_q : 8'(chain_q - 8'd1);
					state_q <= S_DONE;
				end
				S_READ_RD: begin
					state_q <= S_READ_CHK;
				end
				S_READ_CHK: begin
					entry_q <= rd_data;
					used_q  <= (rd_data != 9'd0);
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### hdl/fat_chain_block_allocator.sv
// Top level of the chained block allocator: sequencer, table and result register.
`default_nettype none

// Allocation table of up to 256 entries (the first min(NUM_BLOCKS, 256) blocks), each 0 when
// free, the next block of a chain, or the end marker 511; block 0 is reserved. One request is
// in flight at a time: in_stall is high from the cycle after a transfer until the sequencer has
// handed its result to the output register. Every table look-up goes through the single read
// port of the table memory (address, then registered data). An allocate of n blocks scans
// upward from block 1 until the n-th free block. A free walks the chain one link per look-up.
// A read makes one look-up. Requests refused on their fields alone make none; a free whose
// start block turns out to be free is refused after its look-up. The result register lets the
// next request be accepted while a result still waits on out_stall. No clearing pass follows
// reset: per-entry valid bits, cleared by arst_n, make unwritten entries read as 0.
module fat_chain_block_allocator #(
	parameter int NUM_BLOCKS = fcba_pkg::NUM_BLOCKS_DFLT
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [1:0] req_type,
	input  wire logic [7:0] block_count,
	input  wire logic [7:0] start_block,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [1:0]      status,
	output logic [7:0]      first_block,
	output logic [8:0]      entry_value,
	output logic            block_used,
	output logic [7:0]      free_blocks,
	output logic [7:0]      chain_count
);

	// Only the first 256 blocks are addressable by the 8-bit fields
	localparam int DEPTH = (NUM_BLOCKS < fcba_pkg::MAX_ENTRIES) ? NUM_BLOCKS
	                                                            : fcba_pkg::MAX_ENTRIES;

	fcba_pkg::mem_req_t mem_req;
	fcba_pkg::result_t  res;
	fcba_pkg::result_t  res_q;
	logic [8:0]         rd_data;
	logic               res_valid;
	logic               out_valid_q;
	logic               out_free;

	// The output register is free when empty or when its transfer completes now
	assign out_free = !out_valid_q || !out_stall;

	fcba_seq #(
		.DEPTH(DEPTH)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.req_type   (req_type),
		.block_count(block_count),
		.start_block(start_block),
		.out_free   (out_free),
		.in_stall   (in_stall),
		.mem_req    (mem_req),
		.rd_data    (rd_data),
		.res_valid  (res_valid),
		.res        (res)
	);

	fcba_table #(
		.DEPTH(DEPTH)
	) u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.mem_req(mem_req),
		.rd_data(rd_data)
	);

	// Hold the result until its transfer; load a new one only when the slot is free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			res_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = res_q.status;
	assign first_block = res_q.first_block;
	assign entry_value = res_q.entry_value;
	assign block_used  = res_q.block_used;
	assign free_blocks = res_q.free_blocks;
	assign chain_count = res_q.chain_count;

endmodule

`default_nettype wire

### hdl/fcba_checker.sv
// Port-level checks of the block allocator and their binding.
`default_nettype none
`include "fat_chain_block_allocator_defines.svh"

module fcba_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic [1:0] req_type,
	input wire logic [7:0] block_count,
	input wire logic [7:0] start_block,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [1:0] status,
	input wire logic [7:0] first_block,
	input wire logic [8:0] entry_value,
	input wire logic       block_used,
	input wire logic [7:0] free_blocks,
	input wire logic [7:0] chain_count
);

	// A stalled result must hold
	`FCBA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(first_block) && $stable(entry_value) && $stable(free_blocks) && $stable(chain_count))

	// Every accepted request raises in_stall in the following cycle
	`FCBA_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

	// A refused request carries no chain head and no entry
	`FCBA_ASSERT_NOW(a_err_clean, out_valid && status != fcba_pkg::ST_OK, first_block == 8'd0 && entry_value == 9'd0 && !block_used)

	// The used bit follows the entry returned
	`FCBA_ASSERT_NOW(a_used_bit, out_valid, block_used == (entry_value != 9'd0))

endmodule

bind fat_chain_block_allocator fcba_checker u_fcba_checker (.*);

`default_nettype wire
